// ===== rtl/jsu_pkg.sv =====
// shared types, codes and helper functions for the json string unescape block
package jsu_pkg;

	// input modes
	localparam logic [1:0] MODE_START = 2'd0;
	localparam logic [1:0] MODE_NEXT  = 2'd1;
	localparam logic [1:0] MODE_END   = 2'd2;

	// result status codes
	localparam logic [1:0] ST_BUSY   = 2'd0;
	localparam logic [1:0] ST_CLOSED = 2'd1;
	localparam logic [1:0] ST_ERROR  = 2'd2;

	// error codes
	localparam logic [3:0] ERR_NONE      = 4'd0;
	localparam logic [3:0] ERR_UNTERM    = 4'd1;
	localparam logic [3:0] ERR_CUT_ESC   = 4'd2;
	localparam logic [3:0] ERR_BAD_ESC   = 4'd3;
	localparam logic [3:0] ERR_CTRL      = 4'd4;
	localparam logic [3:0] ERR_SHORT_HEX = 4'd5;
	localparam logic [3:0] ERR_BAD_HEX   = 4'd6;
	localparam logic [3:0] ERR_BAD_LOW   = 4'd7;
	localparam logic [3:0] ERR_UNPAIRED  = 4'd8;

	// characters the decoder looks for
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// surrogate prefixes on bits 15:10
	localparam logic [5:0] SUR_HIGH = 6'b110110;
	localparam logic [5:0] SUR_LOW  = 6'b110111;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] in_byte;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       last_of_run;
		logic [1:0] status;
		logic [3:0] error_code;
	} out_beat_t;

	// utf-8 bytes of one code point, byte 0 first
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;
	} utf8_t;

	// everything one input beat produces
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;
		logic            byte_valid;
		logic [1:0]      status;
		logic [3:0]      error_code;
	} dec_res_t;

	// hex digit value, msb set when the character is a hex digit
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39)
			r = {1'b1, 4'(c - 8'h30)};
		else if (c >= 8'h61 && c <= 8'h66)
			r = {1'b1, 4'(c - 8'h57)};
		else if (c >= 8'h41 && c <= 8'h46)
			r = {1'b1, 4'(c - 8'h37)};
		return r;
	endfunction

	// utf-8 encoding of a 21-bit code point
	function automatic utf8_t utf8_enc(input logic [20:0] cp);
		utf8_t r;
		r.bytes = '0;
		r.last_idx = 2'd0;
		if (cp <= 21'h7F) begin
			r.bytes[0] = cp[7:0];
		end else if (cp <= 21'h7FF) begin
			r.bytes[0] = {3'b110, cp[10:6]};
			r.bytes[1] = {2'b10, cp[5:0]};
			r.last_idx = 2'd1;
		end else if (cp <= 21'hFFFF) begin
			r.bytes[0] = {4'b1110, cp[15:12]};
			r.bytes[1] = {2'b10, cp[11:6]};
			r.bytes[2] = {2'b10, cp[5:0]};
			r.last_idx = 2'd2;
		end else begin
			r.bytes[0] = {5'b11110, cp[20:18]};
			r.bytes[1] = {2'b10, cp[17:12]};
			r.bytes[2] = {2'b10, cp[11:6]};
			r.bytes[3] = {2'b10, cp[5:0]};
			r.last_idx = 2'd3;
		end
		return r;
	endfunction

endpackage

// ===== rtl/jsu_decode.sv =====
// escape decoder state machine: one input beat in, up to four utf-8 bytes out
module jsu_decode import jsu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     take,
	input  in_beat_t beat,
	output dec_res_t res
);

	typedef enum logic [8:0] {
		PH_IDLE      = 9'b000000001,
		PH_BODY      = 9'b000000010,
		PH_ESC       = 9'b000000100,
		PH_HEX_FIRST = 9'b000001000,
		PH_WANT_BSL  = 9'b000010000,
		PH_WANT_U    = 9'b000100000,
		PH_HEX_LOW   = 9'b001000000,
		PH_DONE      = 9'b010000000,
		PH_ERR       = 9'b100000000
	} phase_t;

	phase_t      phase_q, nx_phase, ph;
	logic [15:0] acc_q, nx_acc, acc_shift;
	logic [1:0]  seen_q, nx_seen;
	logic [9:0]  hi_q, nx_hi;
	logic [3:0]  err_q, nx_err;
	logic [4:0]  hv;
	logic        emit;
	logic        raw;
	logic [20:0] cp;
	utf8_t       enc;
	logic [7:0]  b;

	assign b = beat.in_byte;
	assign hv = hex_val(b);
	assign acc_shift = {acc_q[11:0], hv[3:0]};

	// next state and code point for this beat
	always_comb begin
		ph = (beat.mode == MODE_START) ? PH_BODY : phase_q;
		nx_phase = ph;
		nx_acc = acc_q;
		nx_seen = seen_q;
		nx_hi = hi_q;
		nx_err = (beat.mode == MODE_START) ? ERR_NONE : err_q;
		emit = 1'b0;
		raw = 1'b0;
		cp = {13'd0, b};
		if (beat.mode == MODE_END) begin
			case (phase_q)
				PH_BODY: begin
					nx_err = ERR_UNTERM;
					nx_phase = PH_ERR;
				end
				PH_ESC: begin
					nx_err = ERR_CUT_ESC;
					nx_phase = PH_ERR;
				end
				PH_HEX_FIRST, PH_HEX_LOW: begin
					nx_err = ERR_SHORT_HEX;
					nx_phase = PH_ERR;
				end
				PH_WANT_BSL, PH_WANT_U: begin
					nx_err = ERR_UNPAIRED;
					nx_phase = PH_ERR;
				end
				default: ;
			endcase
		end else begin
			case (ph)
				PH_BODY: begin
					if (b == CH_QUOTE) begin
						nx_phase = PH_DONE;
					end else if (b == CH_BSL) begin
						nx_phase = PH_ESC;
					end else if (b < CH_SPACE) begin
						nx_err = ERR_CTRL;
						nx_phase = PH_ERR;
					end else begin
						emit = 1'b1;
						raw = 1'b1;
					end
				end
				PH_ESC: begin
					nx_phase = PH_BODY;
					emit = 1'b1;
					case (b)
						CH_QUOTE, CH_BSL, CH_SLASH: cp = {13'd0, b};
						CH_B: cp = 21'h08;
						CH_F: cp = 21'h0C;
						CH_N: cp = 21'h0A;
						CH_R: cp = 21'h0D;
						CH_T: cp = 21'h09;
						CH_U: begin
							emit = 1'b0;
							nx_acc = 16'd0;
							nx_seen = 2'd0;
							nx_phase = PH_HEX_FIRST;
						end
						default: begin
							emit = 1'b0;
							nx_err = ERR_BAD_ESC;
							nx_phase = PH_ERR;
						end
					endcase
				end
				PH_HEX_FIRST, PH_HEX_LOW: begin
					if (!hv[4]) begin
						nx_err = ERR_BAD_HEX;
						nx_phase = PH_ERR;
					end else begin
						nx_acc = acc_shift;
						if (seen_q != 2'd3) begin
							nx_seen = seen_q + 2'd1;
						end else begin
							nx_seen = 2'd0;
							if (ph == PH_HEX_FIRST) begin
								if (acc_shift[15:10] == SUR_HIGH) begin
									nx_hi = acc_shift[9:0];
									nx_phase = PH_WANT_BSL;
								end else begin
									emit = 1'b1;
									cp = {5'd0, acc_shift};
									nx_phase = PH_BODY;
								end
							end else if (acc_shift[15:10] == SUR_LOW) begin
								emit = 1'b1;
								cp = {1'b0, hi_q, acc_shift[9:0]} + 21'h10000;
								nx_phase = PH_BODY;
							end else begin
								nx_err = ERR_BAD_LOW;
								nx_phase = PH_ERR;
							end
						end
					end
				end
				PH_WANT_BSL: begin
					if (b == CH_BSL) begin
						nx_phase = PH_WANT_U;
					end else begin
						nx_err = ERR_UNPAIRED;
						nx_phase = PH_ERR;
					end
				end
				PH_WANT_U: begin
					if (b == CH_U) begin
						nx_acc = 16'd0;
						nx_seen = 2'd0;
						nx_phase = PH_HEX_LOW;
					end else begin
						nx_err = ERR_UNPAIRED;
						nx_phase = PH_ERR;
					end
				end
				default: ;
			endcase
		end
	end

	// result bytes and status for the serializer
	// plain string bytes pass through as they are, escapes are utf-8 encoded
	assign enc = utf8_enc(cp);
	always_comb begin
		res.bytes = !emit ? '0 : (raw ? {24'd0, b} : enc.bytes);
		res.last_idx = (emit && !raw) ? enc.last_idx : 2'd0;
		res.byte_valid = emit;
		res.error_code = nx_err;
		if (nx_err != ERR_NONE)
			res.status = ST_ERROR;
		else if (nx_phase == PH_DONE)
			res.status = ST_CLOSED;
		else
			res.status = ST_BUSY;
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			acc_q <= 16'd0;
			seen_q <= 2'd0;
			hi_q <= 10'd0;
			err_q <= ERR_NONE;
		end else if (take) begin
			phase_q <= nx_phase;
			acc_q <= nx_acc;
			seen_q <= nx_seen;
			hi_q <= nx_hi;
			err_q <= nx_err;
		end
	end

	// sticky error goes with the error phase and only with it
	a_err_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_ERR) |-> (err_q != ERR_NONE))
		else $error("error phase without error code");
	a_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_ERR) |-> (err_q == ERR_NONE))
		else $error("error code outside error phase");
	// hex digit count only counts up inside a hex escape
	a_seen_hex: assert property (@(posedge clk) disable iff (!arst_n)
		(take && (phase_q != PH_HEX_FIRST) && (phase_q != PH_HEX_LOW))
		|=> ((seen_q == 2'd0) || $stable(seen_q)))
		else $error("hex digit count moved outside hex escape");

endmodule

// ===== rtl/jsu_emit.sv =====
// result register: holds one beat's decoded bytes and hands them out one per cycle while dst_ready is high
module jsu_emit import jsu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  dec_res_t  res,
	output logic      busy,
	output logic      done,
	output logic      dst_valid,
	input  logic      dst_ready,
	output out_beat_t dst_data
);

	logic [3:0][7:0] bytes_q;
	logic [1:0]      last_q;
	logic [1:0]      idx_q;
	logic            valid_q;
	logic            bvalid_q;
	logic [1:0]      status_q;
	logic [3:0]      err_q;
	logic            is_last;

	assign is_last = (idx_q == last_q);
	assign busy = valid_q;
	// the buffer frees up when its last byte leaves
	assign done = valid_q && dst_ready && is_last;

	assign dst_valid = valid_q;
	assign dst_data.out_byte = bytes_q[idx_q];
	assign dst_data.byte_valid = bvalid_q;
	assign dst_data.last_of_run = is_last;
	assign dst_data.status = status_q;
	assign dst_data.error_code = err_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q <= 2'd0;
			last_q <= 2'd0;
			bvalid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q <= 2'd0;
			last_q <= res.last_idx;
			bvalid_q <= res.byte_valid;
		end else if (valid_q && dst_ready) begin
			if (is_last)
				valid_q <= 1'b0;
			else
				idx_q <= idx_q + 2'd1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= res.bytes;
			status_q <= res.status;
			err_q <= res.error_code;
		end
	end

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (idx_q <= last_q))
		else $error("byte index past last byte");
	a_empty_single: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !bvalid_q) |-> (last_q == 2'd0))
		else $error("byte-less result spans several beats");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !dst_ready && !load) |=> (valid_q && $stable(idx_q)))
		else $error("stalled result moved");

endmodule

// ===== rtl/json_string_unescape_utf8.sv =====
// top level of the json string body to utf-8 decoder
//
//  beat    direction  handshake              payload
//  src     in         src_valid/src_ready    in_beat_t  (mode, in_byte)
//  dst     out        dst_valid/dst_ready    out_beat_t (out_byte .. error_code)
//
// one input beat is decoded in the cycle it is accepted and its 1 to 4
// result beats leave from the result register, one per cycle
// a beat giving one result sustains one input beat per cycle; a beat giving
// several bytes holds the input while the result register drains
// src_ready is high when the result register is empty or its last beat leaves
// reset clears the decoder to idle; beats other than a restart are ignored there
// a stall on dst holds the current result beat and, through src_ready, the input
module json_string_unescape_utf8 import jsu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_ready,
	input  in_beat_t  src_data,
	output logic      dst_valid,
	input  logic      dst_ready,
	output out_beat_t dst_data
);

	dec_res_t res;
	logic     take;
	logic     busy;
	logic     done;

	// accept when the result register is free or frees this cycle
	assign src_ready = !busy || done;
	assign take = src_valid && src_ready;

	jsu_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.beat   (src_data),
		.res    (res)
	);

	jsu_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take),
		.res       (res),
		.busy      (busy),
		.done      (done),
		.dst_valid (dst_valid),
		.dst_ready (dst_ready),
		.dst_data  (dst_data)
	);

endmodule
